FILE: rtl/core/fbm_pkg.sv
// fbm_pkg: shared types, constants and table functions for the fractal noise core.
// Depends on nothing; used by fbm_cell, fbm_div and fbm_perlin_noise_2d.
package fbm_pkg;

    // Fixed widths of the datapath
    localparam int COORD_W = 32;
    localparam int FREQ_W  = 32;
    localparam int SUM_W   = 58;
    localparam int TOT_W   = 37;
    localparam int CNT_W   = 5;
    localparam int QUO_W   = 18;
    localparam int DEN_W   = TOT_W + 2;
    localparam int NOISE_W = 16;

    // Q16.16 one, used for initial frequency and amplitude
    localparam logic [FREQ_W-1:0] Q16_ONE = 32'h0001_0000;

    // Fade polynomial coefficients
    localparam logic [37:0] FADE_K6  = 38'd6;
    localparam logic [37:0] FADE_K15 = 38'd15;
    localparam logic [37:0] FADE_K10 = 38'd10 << 32;

    // Gradient hash selectors
    localparam logic [3:0] GRAD_SEL_U = 4'd8;
    localparam logic [3:0] GRAD_SEL_V = 4'd4;
    localparam logic [3:0] GRAD_H_A   = 4'd12;
    localparam logic [3:0] GRAD_H_B   = 4'd14;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_GAIN    = 2'd1;
    localparam logic [1:0] REG_LACUN   = 2'd2;

    // Output saturation bounds
    localparam logic [QUO_W-1:0] SAT_POS = 18'd32767;
    localparam logic [QUO_W-1:0] SAT_NEG = 18'd32768;

    // Point plus running accumulation, passed from cell to cell
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [FREQ_W-1:0]         freq;
        logic [FREQ_W-1:0]         amp;
        logic [FREQ_W-1:0]         amp_nx;
        logic signed [SUM_W-1:0]   sum;
        logic [TOT_W-1:0]          total;
    } t_point;

    // Classic improved-noise permutation
    localparam logic [7:0] PERM_TBL [0:255] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    function automatic logic [7:0] perm_at(input logic [7:0] idx);
        return PERM_TBL[idx];
    endfunction

    // Gradient dot product for one corner, Q16 inputs
    function automatic logic signed [18:0] grad(
        input logic [3:0]         h,
        input logic signed [17:0] x,
        input logic signed [17:0] y
    );
        logic signed [18:0] gu;
        logic signed [18:0] gv;
        gu = (h < GRAD_SEL_U) ? 19'(x) : 19'(y);
        if (h < GRAD_SEL_V) begin
            gv = 19'(y);
        end else if (h == GRAD_H_A || h == GRAD_H_B) begin
            gv = 19'(x);
        end else begin
            gv = '0;
        end
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

endpackage

FILE: rtl/core/fbm_in_if.sv
// fbm_in_if: input channel carrying one Q16.16 point per transaction.
// Depends on nothing.
interface fbm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

FILE: rtl/core/fbm_out_if.sv
// fbm_out_if: output channel carrying one Q2.14 noise sample per transaction.
// Depends on nothing.
interface fbm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

FILE: rtl/core/fbm_cell.sv
// fbm_cell: one octave of Perlin noise, an 8-stage pipeline that adds its weighted
// sample into the running sum when i_active is set. Depends on fbm_pkg.
module fbm_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_active,
    input  logic [15:0]      i_gain,
    input  logic [15:0]      i_lacun,
    input  logic             i_vld,
    input  fbm_pkg::t_point  i_pt,
    output logic             o_vld,
    output fbm_pkg::t_point  o_pt
);

    localparam int LAT = 8;

    logic [LAT-1:0] r_vld;

    // stage 1: scale coordinates, step frequency and amplitude
    logic signed [64:0] n_sx, n_sy;
    logic [47:0]        n_fm, n_am;
    fbm_pkg::t_point    n_pt1;
    fbm_pkg::t_point    r_pt1;
    logic [7:0]         r1_xi, r1_yi;
    logic [15:0]        r1_fx, r1_fy;

    always_comb begin
        n_sx  = $signed(i_pt.cx) * $signed({1'b0, i_pt.freq});
        n_sy  = $signed(i_pt.cy) * $signed({1'b0, i_pt.freq});
        n_fm  = 48'(i_pt.freq) * 48'(i_lacun);
        n_am  = 48'(i_pt.amp) * 48'(i_gain);
        n_pt1 = i_pt;
        n_pt1.freq   = (|n_fm[47:44]) ? '1 : n_fm[43:12];
        n_pt1.amp_nx = (|n_am[47:46]) ? '1 : n_am[45:14];
    end

    // stage 2: squares and first hash level
    logic [31:0]     r2_ttx, r2_tty;
    logic [15:0]     r2_fx, r2_fy;
    logic [8:0]      r2_pa, r2_pb;
    fbm_pkg::t_point r_pt2;

    // stage 3: fade partial products and second hash level
    logic [31:0]     n_t3x, n_t3y;
    logic [37:0]     n_pfx, n_pfy;
    logic [15:0]     r3_t3x, r3_t3y;
    logic [19:0]     r3_px, r3_py;
    logic [15:0]     r3_fx, r3_fy;
    logic [7:0]      r3_qa, r3_qa1, r3_qb, r3_qb1;
    fbm_pkg::t_point r_pt3;

    always_comb begin
        n_t3x = 32'(r2_ttx[31:16]) * 32'(r2_fx);
        n_t3y = 32'(r2_tty[31:16]) * 32'(r2_fy);
        n_pfx = 38'(r2_ttx) * fbm_pkg::FADE_K6 + fbm_pkg::FADE_K10
              - ((38'(r2_fx) * fbm_pkg::FADE_K15) << 16);
        n_pfy = 38'(r2_tty) * fbm_pkg::FADE_K6 + fbm_pkg::FADE_K10
              - ((38'(r2_fy) * fbm_pkg::FADE_K15) << 16);
    end

    // stage 4: fade result, corner hashes and gradients
    logic [35:0]        n_ux, n_uy;
    logic [3:0]         n_haa, n_hab, n_hba, n_hbb;
    logic signed [17:0] n_x0, n_x1, n_y0, n_y1;
    logic [16:0]        r4_u, r4_v;
    logic signed [18:0] r4_gaa, r4_gba, r4_gab, r4_gbb;
    fbm_pkg::t_point    r_pt4;

    always_comb begin
        n_ux  = 36'(r3_t3x) * 36'(r3_px);
        n_uy  = 36'(r3_t3y) * 36'(r3_py);
        n_haa = fbm_pkg::PERM_TBL[r3_qa][3:0];
        n_hab = fbm_pkg::PERM_TBL[r3_qa1][3:0];
        n_hba = fbm_pkg::PERM_TBL[r3_qb][3:0];
        n_hbb = fbm_pkg::PERM_TBL[r3_qb1][3:0];
        n_x0  = $signed({2'b00, r3_fx});
        n_x1  = $signed({2'b11, r3_fx});
        n_y0  = $signed({2'b00, r3_fy});
        n_y1  = $signed({2'b11, r3_fy});
    end

    // stage 5: interpolate along x
    logic signed [19:0] n_dlo, n_dhi;
    logic signed [37:0] n_mlo, n_mhi;
    logic signed [21:0] n_lo, n_hi;
    logic signed [21:0] r5_lo, r5_hi;
    logic [16:0]        r5_v;
    fbm_pkg::t_point    r_pt5;

    always_comb begin
        n_dlo = 20'(r4_gba) - 20'(r4_gaa);
        n_dhi = 20'(r4_gbb) - 20'(r4_gab);
        n_mlo = $signed({1'b0, r4_u}) * n_dlo;
        n_mhi = $signed({1'b0, r4_u}) * n_dhi;
        n_lo  = 22'(r4_gaa) + $signed(n_mlo[37:16]);
        n_hi  = 22'(r4_gab) + $signed(n_mhi[37:16]);
    end

    // stage 6: interpolate along y
    logic signed [22:0] n_dy;
    logic signed [40:0] n_my;
    logic signed [22:0] r6_nz;
    fbm_pkg::t_point    r_pt6;

    always_comb begin
        n_dy = 23'(r5_hi) - 23'(r5_lo);
        n_my = $signed({1'b0, r5_v}) * n_dy;
    end

    logic signed [22:0] n_nz;
    assign n_nz = 23'(r5_lo) + $signed(n_my[38:16]);

    // stage 7: weight by amplitude
    logic signed [55:0] r7_prod;
    fbm_pkg::t_point    r_pt7;

    // stage 8: accumulate
    fbm_pkg::t_point n_pt8;
    fbm_pkg::t_point r_pt8;

    always_comb begin
        n_pt8     = r_pt7;
        n_pt8.amp = r_pt7.amp_nx;
        if (i_active) begin
            n_pt8.sum   = r_pt7.sum + fbm_pkg::SUM_W'(r7_prod);
            n_pt8.total = r_pt7.total + fbm_pkg::TOT_W'(r_pt7.amp);
        end
    end

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt1  <= n_pt1;
            r1_xi  <= n_sx[39:32];
            r1_yi  <= n_sy[39:32];
            r1_fx  <= n_sx[31:16];
            r1_fy  <= n_sy[31:16];

            r_pt2  <= r_pt1;
            r2_ttx <= 32'(r1_fx) * 32'(r1_fx);
            r2_tty <= 32'(r1_fy) * 32'(r1_fy);
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_pa  <= 9'(fbm_pkg::perm_at(r1_xi)) + 9'(r1_yi);
            r2_pb  <= 9'(fbm_pkg::perm_at(r1_xi + 8'd1)) + 9'(r1_yi);

            r_pt3  <= r_pt2;
            r3_t3x <= n_t3x[31:16];
            r3_t3y <= n_t3y[31:16];
            r3_px  <= n_pfx[35:16];
            r3_py  <= n_pfy[35:16];
            r3_fx  <= r2_fx;
            r3_fy  <= r2_fy;
            r3_qa  <= fbm_pkg::perm_at(r2_pa[7:0]);
            r3_qa1 <= fbm_pkg::perm_at(r2_pa[7:0] + 8'd1);
            r3_qb  <= fbm_pkg::perm_at(r2_pb[7:0]);
            r3_qb1 <= fbm_pkg::perm_at(r2_pb[7:0] + 8'd1);

            r_pt4  <= r_pt3;
            r4_u   <= n_ux[32:16];
            r4_v   <= n_uy[32:16];
            r4_gaa <= fbm_pkg::grad(n_haa, n_x0, n_y0);
            r4_gba <= fbm_pkg::grad(n_hba, n_x1, n_y0);
            r4_gab <= fbm_pkg::grad(n_hab, n_x0, n_y1);
            r4_gbb <= fbm_pkg::grad(n_hbb, n_x1, n_y1);

            r_pt5  <= r_pt4;
            r5_lo  <= n_lo;
            r5_hi  <= n_hi;
            r5_v   <= r4_v;

            r_pt6  <= r_pt5;
            r6_nz  <= n_nz;

            r_pt7   <= r_pt6;
            r7_prod <= 56'(r6_nz) * $signed({24'b0, r_pt6.amp});

            r_pt8 <= n_pt8;
        end
    end

    assign o_vld = r_vld[LAT-1];
    assign o_pt  = r_pt8;

endmodule

FILE: rtl/core/fbm_div.sv
// fbm_div: pipelined restoring divider, sum / (4 * total), one quotient bit per stage,
// truncated toward zero and saturated to Q2.14. Depends on fbm_pkg.
module fbm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic signed [fbm_pkg::SUM_W-1:0] i_sum,
    input  logic [fbm_pkg::TOT_W-1:0]        i_total,
    output logic                             o_vld,
    output logic signed [15:0]               o_noise
);

    localparam int QW = fbm_pkg::QUO_W;
    localparam int RW = fbm_pkg::SUM_W;
    localparam int DW = fbm_pkg::DEN_W;

    logic [QW:0]    r_vld;
    logic [RW-1:0]  r_rem  [0:QW];
    logic [QW-1:0]  r_quo  [0:QW];
    logic [DW-1:0]  r_den  [0:QW];
    logic           r_neg  [0:QW];
    logic           r_zero [0:QW];

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    // load: magnitude of the sum and the denominator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_sum[RW-1] ? RW'(-i_sum) : RW'(i_sum);
            r_quo[0]  <= '0;
            r_den[0]  <= {i_total, 2'b00};
            r_neg[0]  <= i_sum[RW-1];
            r_zero[0] <= (i_total == '0);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int K = QW - 1 - j;
        logic [RW-1:0] w_dsh;
        logic          w_ge;
        assign w_dsh = RW'(r_den[j]) << K;
        assign w_ge  = (r_rem[j] >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_ge ? (r_rem[j] - w_dsh) : r_rem[j];
                r_quo[j+1]  <= r_quo[j] | (QW'(w_ge) << K);
                r_den[j+1]  <= r_den[j];
                r_neg[j+1]  <= r_neg[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // sign and saturation
    logic [QW-1:0] w_q;
    assign w_q = r_quo[QW];

    always_comb begin
        if (r_zero[QW]) begin
            o_noise = '0;
        end else if (r_neg[QW]) begin
            o_noise = (w_q >= fbm_pkg::SAT_NEG) ? 16'sh8000 : -$signed(w_q[15:0]);
        end else begin
            o_noise = (w_q >= fbm_pkg::SAT_POS) ? 16'sh7fff : $signed(w_q[15:0]);
        end
    end

    assign o_vld = r_vld[QW];

endmodule

FILE: rtl/core/fbm_perlin_noise_2d.sv
// fbm_perlin_noise_2d: fractal Brownian motion over 2D improved Perlin noise.
// Pipeline: MAX_OCTAVES octave cells in a chain, then the divider, then the output register.
// Throughput: one point per cycle; the whole pipeline stalls only when a result
// waits at the output and another reaches it. Unused octave cells pass data on.
// Reset (sync, active low) clears valid state; octave_count=4, gain=0.5, lacunarity=2.0.
// Depends on fbm_pkg, fbm_in_if, fbm_out_if, fbm_cell, fbm_div.
module fbm_perlin_noise_2d #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbm_in_if.sink      i_pt,
    fbm_out_if.source   o_noise,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = fbm_pkg::CNT_W;

    // configuration registers
    logic [3:0]  r_oct;
    logic [15:0] r_gain;
    logic [15:0] r_lacun;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct   <= 4'd4;
            r_gain  <= 16'd8192;
            r_lacun <= 16'd8192;
        end else if (w_wr) begin
            case (paddr[3:2])
                fbm_pkg::REG_OCTAVES: r_oct   <= pwdata[3:0];
                fbm_pkg::REG_GAIN:    r_gain  <= pwdata[15:0];
                fbm_pkg::REG_LACUN:   r_lacun <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fbm_pkg::REG_OCTAVES: prdata = {28'b0, r_oct};
            fbm_pkg::REG_GAIN:    prdata = {16'b0, r_gain};
            fbm_pkg::REG_LACUN:   prdata = {16'b0, r_lacun};
            default:              prdata = '0;
        endcase
    end

    // effective octave count
    logic [CW-1:0] w_nsat;
    assign w_nsat = (CW'(r_oct) > CW'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(r_oct);

    // pipeline advance: blocked only when a result waits and another arrives
    logic w_en;
    logic w_div_vld;
    logic signed [15:0] w_div_val;
    logic r_out_vld;
    logic signed [15:0] r_out_val;

    assign w_en       = ~r_out_vld | o_noise.ready | ~w_div_vld;
    assign i_pt.ready = w_en;

    // chain of octave cells
    logic            w_vld [0:MAX_OCTAVES];
    fbm_pkg::t_point w_pt  [0:MAX_OCTAVES];

    always_comb begin
        w_pt[0]        = '0;
        w_pt[0].cx     = i_pt.coord_x;
        w_pt[0].cy     = i_pt.coord_y;
        w_pt[0].freq   = fbm_pkg::Q16_ONE;
        w_pt[0].amp    = fbm_pkg::Q16_ONE;
        w_pt[0].amp_nx = fbm_pkg::Q16_ONE;
    end
    assign w_vld[0] = i_pt.valid;

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
        fbm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_active (CW'(i) < w_nsat),
            .i_gain   (r_gain),
            .i_lacun  (r_lacun),
            .i_vld    (w_vld[i]),
            .i_pt     (w_pt[i]),
            .o_vld    (w_vld[i+1]),
            .o_pt     (w_pt[i+1])
        );
    end

    // normalization
    fbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[MAX_OCTAVES]),
        .i_sum   (w_pt[MAX_OCTAVES].sum),
        .i_total (w_pt[MAX_OCTAVES].total),
        .o_vld   (w_div_vld),
        .o_noise (w_div_val)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en & w_div_vld) begin
            r_out_vld <= 1'b1;
        end else if (o_noise.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en & w_div_vld) begin
            r_out_val <= w_div_val;
        end
    end

    assign o_noise.valid       = r_out_vld;
    assign o_noise.noise_value = r_out_val;

endmodule
